[src/ima_pkg.sv]
package ima_pkg;

  localparam int Channels     = 7;
  localparam int MaxWindowDef = 32;
  localparam int SampleW      = 16;
  localparam int WinW         = 6;

  localparam logic [WinW-1:0] WinReset = 6'd8;

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
    logic signed [SampleW-1:0] temperature;
    logic signed [SampleW-1:0] gyro_x;
    logic signed [SampleW-1:0] gyro_y;
    logic signed [SampleW-1:0] gyro_z;
  } ima_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] avg_accel_x;
    logic signed [SampleW-1:0] avg_accel_y;
    logic signed [SampleW-1:0] avg_accel_z;
    logic signed [SampleW-1:0] avg_temperature;
    logic signed [SampleW-1:0] avg_gyro_x;
    logic signed [SampleW-1:0] avg_gyro_y;
    logic signed [SampleW-1:0] avg_gyro_z;
  } ima_out_t;

  // Control strobes broadcast from the sequencer to every lane.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clr;
    logic div_start;
  } ima_lane_ctrl_t;

endpackage

[src/ima_ram.sv]
module ima_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ima_lane.sv]
module ima_lane
  import ima_pkg::*;
#(
  parameter int MaxWindow = MaxWindowDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ima_lane_ctrl_t               ctrl_i,
  input  logic [$clog2(MaxWindow)-1:0] wr_addr_i,
  input  logic [SampleW-1:0]           wr_data_i,
  input  logic [$clog2(MaxWindow)-1:0] rd_addr_i,
  input  logic [$clog2(MaxWindow+1)-1:0] den_i,
  output logic [SampleW-1:0]           res_o,
  output logic                         done_o
);

  localparam int PtrW = $clog2(MaxWindow);
  localparam int CntW = $clog2(MaxWindow + 1);
  localparam int SumW = SampleW + PtrW;
  localparam int ItW  = $clog2(SumW);

  logic [SampleW-1:0] rd_data;
  logic               dv_q;
  logic [SumW-1:0]    acc_q, acc_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [ItW-1:0]     it_q, it_d;
  logic               neg_q, neg_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [SampleW-1:0] res_q, res_d;
  logic [CntW:0]      trial;
  logic               ge;
  logic [SumW-1:0]    shifted;
  logic [SumW-1:0]    acc_mag;

  ima_ram #(
    .Width(SampleW),
    .Depth(MaxWindow)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rd_data)
  );

  assign acc_mag = acc_q[SumW-1] ? (~acc_q + 1'b1) : acc_q;
  assign trial   = {rem_q, quo_q[SumW-1]};
  assign ge      = trial >= {1'b0, den_i};
  assign shifted = {quo_q[SumW-2:0], ge};

  always_comb begin
    acc_d  = acc_q;
    busy_d = busy_q;
    done_d = 1'b0;
    it_d   = it_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (dv_q) begin
      acc_d = acc_q + {{(SumW-SampleW){rd_data[SampleW-1]}}, rd_data};
    end
    if (ctrl_i.div_start) begin
      // Divide the magnitude and restore the sign, which truncates toward zero.
      neg_d  = acc_q[SumW-1];
      quo_d  = acc_mag;
      rem_d  = '0;
      it_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = shifted;
      rem_d = ge ? CntW'(trial - {1'b0, den_i}) : trial[CntW-1:0];
      it_d  = it_q + 1'b1;
      if (it_q == ItW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (~shifted[SampleW-1:0] + 1'b1) : shifted[SampleW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      dv_q   <= ctrl_i.rd_en;
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

[src/imu_moving_average_core.sv]
// Flow: an input transfer writes the history RAMs, then the per-lane accumulate loop reads
// back over N samples, where N is the filled count (at most the window), and the bit-serial
// divider forms each mean. The input stalls from a transfer until its result is loaded into
// the output register, so one item is in flight at a time. A new input is taken while a result waits.
// Reset: rst_ni clears the sequencer, write pointer, filled count and output valid, and
// sets the window to 8; the history RAMs are not cleared and are read only once written.
module imu_moving_average_core
  import ima_pkg::*;
#(
  parameter int MaxWindow = MaxWindowDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ima_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ima_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [WinW-1:0] cfg_data_i
);

  localparam int PtrW = $clog2(MaxWindow);
  localparam int CntW = $clog2(MaxWindow + 1);
  localparam int CmpW = (CntW > WinW) ? CntW + 1 : WinW + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ACC   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_START = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } ima_state_e;

  ima_state_e      state_q, state_d;
  logic [PtrW-1:0] pos_q, pos_d;
  logic [PtrW-1:0] rd_addr_q, rd_addr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic [WinW-1:0] win_q;
  logic            out_valid_q, out_valid_d;
  ima_out_t        out_data_q;
  logic            load_out;

  logic [CmpW-1:0] win_ext, win_eff, cnt_inc;
  logic            in_xfer;

  ima_lane_ctrl_t     lane_ctrl;
  logic [SampleW-1:0] lane_in  [Channels];
  logic [SampleW-1:0] lane_res [Channels];
  logic [Channels-1:0] lane_done;

  assign lane_in[0] = in_data_i.accel_x;
  assign lane_in[1] = in_data_i.accel_y;
  assign lane_in[2] = in_data_i.accel_z;
  assign lane_in[3] = in_data_i.temperature;
  assign lane_in[4] = in_data_i.gyro_x;
  assign lane_in[5] = in_data_i.gyro_y;
  assign lane_in[6] = in_data_i.gyro_z;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Window of zero counts as one; anything above the history depth saturates.
  assign win_ext = CmpW'(win_q);
  always_comb begin
    priority if (win_q == '0) begin
      win_eff = CmpW'(1);
    end else if (win_ext > CmpW'(MaxWindow)) begin
      win_eff = CmpW'(MaxWindow);
    end else begin
      win_eff = win_ext;
    end
  end
  assign cnt_inc = CmpW'(cnt_q) + 1'b1;

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rd_addr_d   = rd_addr_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    lane_ctrl   = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          lane_ctrl.wr_en   = 1'b1;
          lane_ctrl.acc_clr = 1'b1;
          cnt_d     = (cnt_inc > win_eff) ? CntW'(win_eff) : CntW'(cnt_inc);
          rd_addr_d = pos_q;
          iss_d     = '0;
          pos_d     = (pos_q == PtrW'(MaxWindow - 1)) ? '0 : pos_q + 1'b1;
          state_d   = ST_ACC;
        end
      end
      ST_ACC: begin
        // Walk backward from the newest slot, one read per cycle.
        lane_ctrl.rd_en = 1'b1;
        rd_addr_d = (rd_addr_q == '0) ? PtrW'(MaxWindow - 1) : rd_addr_q - 1'b1;
        iss_d     = iss_q + 1'b1;
        if (iss_q == cnt_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_START;
      end
      ST_START: begin
        lane_ctrl.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (lane_done[0]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < Channels; g++) begin : g_lane
    ima_lane #(
      .MaxWindow(MaxWindow)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .wr_addr_i(pos_q),
      .wr_data_i(lane_in[g]),
      .rd_addr_i(rd_addr_q),
      .den_i    (cnt_q),
      .res_o    (lane_res[g]),
      .done_o   (lane_done[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      rd_addr_q   <= '0;
      cnt_q       <= '0;
      iss_q       <= '0;
      win_q       <= WinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rd_addr_q   <= rd_addr_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
    end
  end

  // Merge stage: gather the lane means into the output record.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.avg_accel_x     <= lane_res[0];
      out_data_q.avg_accel_y     <= lane_res[1];
      out_data_q.avg_accel_z     <= lane_res[2];
      out_data_q.avg_temperature <= lane_res[3];
      out_data_q.avg_gyro_x      <= lane_res[4];
      out_data_q.avg_gyro_y      <= lane_res[5];
      out_data_q.avg_gyro_z      <= lane_res[6];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q != '0 && CmpW'(cnt_q) <= CmpW'(MaxWindow)))
    else $error("filled count out of range while busy");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> (state_q == ST_DIV))
    else $error("lane finished outside the divide phase");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_done == '0) || (&lane_done))
    else $error("lanes out of step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result overwritten");
`endif

endmodule
